// ===== hdl/pfh_pkg.sv =====
// Shared types and constants for the fractal height sampler.
`timescale 1ns / 1ps
package pfh_pkg;
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_BASE_FREQUENCY = 2'd0;
   localparam logic [1:0] CSR_BASE_AMPLITUDE = 2'd1;
   localparam logic [1:0] CSR_OCTAVE_COUNT   = 2'd2;

   localparam int HEIGHT_W = 41;

   // Work item passed from the front part to the back part.
   typedef struct packed {
      logic        is_load;
      logic [7:0]  table_index;
      logic [7:0]  table_value;
      logic        outside;
      logic [39:0] px;
      logic [39:0] pz;
   } pfh_job_type;
endpackage

// ===== hdl/perlin_fbm_height_sampler.sv =====
// Top level of the fractal Perlin height sampler.
// A load request is queued and written to the table when the back part takes it from the queue.
// A sample's result sums N octaves (N = the octave count clamped to MAX_OCTAVES).
// The octave sequencer works through one sample at a time and takes no new job until its height is registered.
// A two-entry queue lets the next request be accepted while a sample runs.
// Synchronous reset restores the register defaults; the table is not cleared.
`timescale 1ns / 1ps
module perlin_fbm_height_sampler
   import pfh_pkg::*;
#(
   parameter int GRID_COORD_LIMIT = 4096,
   parameter int MAX_OCTAVES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   input  logic [11:0]        req_grid_x,
   input  logic [11:0]        req_grid_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [40:0] rsp_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   logic [23:0] base_frequency_ff;
   logic [31:0] base_amplitude_ff;
   logic [4:0]  octave_count_ff;
   logic        job_valid, job_ready;
   pfh_job_type job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_frequency_ff <= 24'd1311;
         base_amplitude_ff <= 32'd65536;
         octave_count_ff   <= 5'd4;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_FREQUENCY: base_frequency_ff <= csr_data[23:0];
            CSR_BASE_AMPLITUDE: base_amplitude_ff <= csr_data;
            CSR_OCTAVE_COUNT:   octave_count_ff   <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   pfh_front #(.COORD_W(12), .GRID_COORD_LIMIT(GRID_COORD_LIMIT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_table_index,
      .req_table_value, .req_grid_x, .req_grid_z,
      .base_frequency(base_frequency_ff),
      .job_valid, .job_ready, .job
   );

   pfh_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .base_amplitude(base_amplitude_ff), .octave_count(octave_count_ff),
      .rsp_valid, .rsp_ready, .rsp_height
   );
endmodule

// ===== hdl/pfh_front.sv =====
// Front part: takes requests, scales the grid point and queues the work.
`timescale 1ns / 1ps
module pfh_front
   import pfh_pkg::*;
#(
   parameter int COORD_W = 12,
   parameter int GRID_COORD_LIMIT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   input  logic [COORD_W-1:0] req_grid_x,
   input  logic [COORD_W-1:0] req_grid_z,
   input  logic [23:0]        base_frequency,
   output logic               job_valid,
   input  logic               job_ready,
   output pfh_job_type        job
);
   localparam int DEPTH = 2;

   pfh_job_type queue_ff [DEPTH];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   pfh_job_type job_in;
   logic        push, pop;
   logic [39:0] px_wide, pz_wide;

   assign req_ready = (count_ff != 2'(DEPTH));
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      px_wide = 40'(req_grid_x) * 40'(base_frequency);
      pz_wide = 40'(req_grid_z) * 40'(base_frequency);
      job_in.is_load     = (req_operation == OP_LOAD);
      job_in.table_index = req_table_index;
      job_in.table_value = req_table_value;
      job_in.outside     = (32'(req_grid_x) >= 32'(GRID_COORD_LIMIT)) ||
                           (32'(req_grid_z) >= 32'(GRID_COORD_LIMIT));
      job_in.px          = px_wide;
      job_in.pz          = pz_wide;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(DEPTH)) |-> !push) else $error("push into full queue");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 2'd1)
      else $error("pop did not shrink queue");
endmodule

// ===== hdl/pfh_back.sv =====
// Back part: table loads and the octave sequencer with one shared noise step.
`timescale 1ns / 1ps
module pfh_back
   import pfh_pkg::*;
#(
   parameter int MAX_OCTAVES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  pfh_job_type        job,
   input  logic [31:0]        base_amplitude,
   input  logic [4:0]         octave_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [40:0] rsp_height
);
   typedef enum logic [3:0] {
      S_IDLE, S_START, S_RD_PX, S_RD_H, S_FADE1, S_FADE2, S_FADE3,
      S_BLEND1, S_BLEND2, S_ACC, S_DONE
   } state_type;

   state_type        state_ff;
   logic [7:0]       perm_mem [256];
   logic [7:0]       rd_addr [2];
   logic [7:0]       rd_data_ff [2];
   logic [39:0]      px_ff, pz_ff;
   logic [5:0]       oct_ff, noct_ff;
   logic [7:0]       xi_ff, zi_ff;
   logic [16:0]      xf_ff, zf_ff;
   logic [7:0]       px0_ff, px1_ff;
   logic [7:0]       h_ff [4];
   logic [33:0]      t2x_ff, t2z_ff, t3x_ff, t3z_ff, inx_ff, inz_ff;
   logic [33:0]      u_ff, v_ff;
   logic signed [35:0] lower_ff, upper_ff, noise_ff;
   logic signed [47:0] sum_ff;
   logic signed [40:0] height_ff;
   logic        rsp_valid_ff;
   logic [39:0] cx_sh, cz_sh;
   logic [1:0]  rd_sel_ff;
   logic        outside_ff;

   function automatic logic signed [35:0] grad(input logic [7:0] h,
         input logic signed [35:0] x, input logic signed [35:0] y);
      unique case (h[1:0])
         2'd0: grad = x + y;
         2'd1: grad = -x + y;
         2'd2: grad = x - y;
         default: grad = -x - y;
      endcase
   endfunction

   // The fade weight never exceeds 1.0, so 17 bits of it carry the whole value.
   function automatic logic signed [35:0] blend(input logic signed [35:0] a,
         input logic signed [35:0] b, input logic [33:0] w);
      logic signed [71:0] prod;
      prod  = $signed({1'b0, w[16:0]}) * (b - a);
      blend = a + 36'(prod >>> 16);
   endfunction

   logic signed [35:0] xs, zs, xm, zm;
   logic [31:0]        amp_sh;
   logic signed [52:0] contrib;
   logic signed [47:0] sum_sat_in;
   logic [5:0]         ncl;
   logic               rsp_free;

   // The noise of one octave stays within 20 signed bits.
   always_comb begin
      cx_sh = px_ff << oct_ff;
      cz_sh = pz_ff << oct_ff;
      xs = 36'(xf_ff);
      zs = 36'(zf_ff);
      xm = xs - 36'sd65536;
      zm = zs - 36'sd65536;
      amp_sh = base_amplitude >> oct_ff;
      contrib = $signed(noise_ff[19:0]) * $signed({1'b0, amp_sh});
      ncl = (6'(octave_count) > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : 6'(octave_count);
      rd_addr[0] = xi_ff;
      rd_addr[1] = xi_ff + 8'd1;
      if (rd_sel_ff == 2'd1) begin
         rd_addr[0] = px1_ff + zi_ff;
         rd_addr[1] = px1_ff + zi_ff + 8'd1;
      end else if (rd_sel_ff == 2'd3) begin
         rd_addr[0] = px0_ff + zi_ff;
         rd_addr[1] = px0_ff + zi_ff + 8'd1;
      end
      sum_sat_in = sum_ff;
   end

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign job_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = height_ff;

   always_ff @(posedge clock) begin
      if (job_valid && job_ready && job.is_load) begin
         perm_mem[job.table_index] <= job.table_value;
      end
      for (int i = 0; i < 2; i++) begin
         rd_data_ff[i] <= perm_mem[rd_addr[i]];
      end
   end

   // The octave sequencer: fetch indices, fetch corner hashes, fade, blend, accumulate; then saturate the sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_sel_ff    <= 2'd0;
      end else begin
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid && job_ready && !job.is_load) begin
                  px_ff      <= job.px;
                  pz_ff      <= job.pz;
                  outside_ff <= job.outside;
                  oct_ff     <= 6'd0;
                  noct_ff    <= ncl;
                  sum_ff     <= 48'sd0;
                  state_ff   <= S_START;
               end
            end
            S_START: begin
               if (outside_ff || oct_ff == noct_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  xi_ff     <= cx_sh[23:16];
                  zi_ff     <= cz_sh[23:16];
                  xf_ff     <= {1'b0, cx_sh[15:0]};
                  zf_ff     <= {1'b0, cz_sh[15:0]};
                  rd_sel_ff <= 2'd0;
                  state_ff  <= S_RD_PX;
               end
            end
            S_RD_PX: begin
               // Wait for the registered table read of px0 and px1.
               if (rd_sel_ff == 2'd0) begin
                  rd_sel_ff <= 2'd2;
               end else begin
                  px0_ff    <= rd_data_ff[0];
                  px1_ff    <= rd_data_ff[1];
                  rd_sel_ff <= 2'd3;
                  state_ff  <= S_RD_H;
               end
               t2x_ff <= 34'((xf_ff * xf_ff) >> 16);
               t2z_ff <= 34'((zf_ff * zf_ff) >> 16);
            end
            S_RD_H: begin
               unique case (rd_sel_ff)
                  2'd3: rd_sel_ff <= 2'd0;
                  2'd0: begin
                     h_ff[0]   <= rd_data_ff[0];
                     h_ff[1]   <= rd_data_ff[1];
                     rd_sel_ff <= 2'd1;
                  end
                  2'd1: rd_sel_ff <= 2'd2;
                  default: begin
                     h_ff[2]  <= rd_data_ff[0];
                     h_ff[3]  <= rd_data_ff[1];
                     state_ff <= S_FADE1;
                  end
               endcase
            end
            S_FADE1: begin
               t3x_ff <= 34'((t2x_ff * 34'(xf_ff)) >> 16);
               t3z_ff <= 34'((t2z_ff * 34'(zf_ff)) >> 16);
               inx_ff <= 34'd6 * t2x_ff + 34'd655360 - 34'd15 * 34'(xf_ff);
               inz_ff <= 34'd6 * t2z_ff + 34'd655360 - 34'd15 * 34'(zf_ff);
               state_ff <= S_FADE2;
            end
            S_FADE2: begin
               u_ff <= 34'((t3x_ff * inx_ff) >> 16);
               v_ff <= 34'((t3z_ff * inz_ff) >> 16);
               state_ff <= S_FADE3;
            end
            S_FADE3: begin
               lower_ff <= blend(grad(h_ff[0], xs, zs), grad(h_ff[2], xm, zs), u_ff);
               upper_ff <= blend(grad(h_ff[1], xs, zm), grad(h_ff[3], xm, zm), u_ff);
               state_ff <= S_BLEND1;
            end
            S_BLEND1: begin
               noise_ff <= blend(lower_ff, upper_ff, v_ff);
               state_ff <= S_ACC;
            end
            S_BLEND2: state_ff <= S_ACC;
            S_ACC: begin
               sum_ff   <= sum_ff + 48'(contrib >>> 16);
               oct_ff   <= oct_ff + 6'd1;
               state_ff <= S_START;
            end
            S_DONE: begin
               // The finished height waits here while the previous one is unread.
               if (rsp_free) begin
                  if (outside_ff) begin
                     height_ff <= 41'sd0;
                  end else if (sum_sat_in > 48'sh0FF_FFFF_FFFF) begin
                     height_ff <= {1'b0, {40{1'b1}}};
                  end else if (sum_sat_in < -48'sh100_0000_0000) begin
                     height_ff <= {1'b1, {40{1'b0}}};
                  end else begin
                     height_ff <= sum_sat_in[40:0];
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !job_ready) else $error("job taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid_ff) else $error("result lost");
   a_oct_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> oct_ff <= noct_ff) else $error("octave overrun");
endmodule

// ===== sim/perlin_fbm_height_sampler_tb.sv =====
// Self-checking testbench for the fractal Perlin height sampler.
`timescale 1ns / 1ps
module perlin_fbm_height_sampler_tb;
   import pfh_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int OCTAVE_CAP = 16;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = OP_LOAD;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic [11:0]        req_grid_x = '0;
   logic [11:0]        req_grid_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [40:0] rsp_height;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_BASE_FREQUENCY;
   logic [31:0]        csr_data = '0;

   perlin_fbm_height_sampler u_top (.*);

   always #2 clock = ~clock;

   // Model state, kept in step with accepted requests and register writes.
   logic [7:0]  perm[256];
   logic [23:0] frequency;
   logic [31:0] amplitude;
   logic [4:0]  octaves;

   logic signed [40:0] heights_due[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   typedef struct {
      logic        op;
      logic [7:0]  idx;
      logic [7:0]  val;
      logic [11:0] gx;
      logic [11:0] gz;
      bit          typed;
      logic signed [40:0] height;
   } row_type;

   row_type directed[14] = '{
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd4095, 12'd4095, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd4095, 12'd0, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd0, 12'd4095, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd1, 12'd1, 1'b0, 41'sd0},
      '{OP_LOAD, 8'd0, 8'd255, 12'd0, 12'd0, 1'b0, 41'sd0},
      '{OP_LOAD, 8'd255, 8'd0, 12'd0, 12'd0, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd0, 12'd0, 1'b1, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd2048, 12'd2048, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd4094, 12'd1, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd50, 12'd3000, 1'b0, 41'sd0},
      '{OP_LOAD, 8'd170, 8'd85, 12'd0, 12'd0, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd2730, 12'd1365, 1'b0, 41'sd0},
      '{OP_SAMPLE, 8'd0, 8'd0, 12'd100, 12'd100, 1'b0, 41'sd0}
   };

   function automatic longint fade(longint f);
      longint t2, t3;
      t2 = (f * f) >> 16;
      t3 = (t2 * f) >> 16;
      return (t3 * (6 * t2 + 10 * 65536 - 15 * f)) >> 16;
   endfunction

   function automatic longint corner(logic [7:0] hash, longint x, longint y);
      case (hash[1:0])
         2'd0: return x + y;
         2'd1: return -x + y;
         2'd2: return x - y;
         default: return -x - y;
      endcase
   endfunction

   // Arithmetic shift on a signed longint rounds toward minus infinity.
   function automatic longint mix(longint a, longint b, longint w);
      return a + ((w * (b - a)) >>> 16);
   endfunction

   function automatic longint noise(logic [23:0] cx, logic [23:0] cz);
      logic [7:0] xi, zi, px0, px1, aa, ab, ba, bb;
      longint xf, zf, u, v, lower, upper;
      xi = cx[23:16];
      zi = cz[23:16];
      xf = longint'(cx[15:0]);
      zf = longint'(cz[15:0]);
      u = fade(xf);
      v = fade(zf);
      px0 = perm[xi];
      px1 = perm[8'(xi + 8'd1)];
      aa = perm[8'(px0 + zi)];
      ab = perm[8'(px0 + zi + 8'd1)];
      ba = perm[8'(px1 + zi)];
      bb = perm[8'(px1 + zi + 8'd1)];
      lower = mix(corner(aa, xf, zf), corner(ba, xf - 65536, zf), u);
      upper = mix(corner(ab, xf, zf - 65536), corner(bb, xf - 65536, zf - 65536), u);
      return mix(lower, upper, v);
   endfunction

   function automatic logic signed [40:0] terrain_height(logic [11:0] gx, logic [11:0] gz);
      longint px, pz, sum, amp;
      int n;
      logic [23:0] cx, cz;
      px = longint'(gx) * longint'(frequency);
      pz = longint'(gz) * longint'(frequency);
      n = (octaves > OCTAVE_CAP) ? OCTAVE_CAP : int'(octaves);
      sum = 0;
      for (int k = 0; k < n; k++) begin
         cx = 24'(px << k);
         cz = 24'(pz << k);
         amp = longint'(amplitude) >> k;
         sum += (noise(cx, cz) * amp) >>> 16;
      end
      if (sum > 64'sd1099511627775) sum = 64'sd1099511627775;
      if (sum < -64'sd1099511627776) sum = -64'sd1099511627776;
      return 41'(sum);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_request(logic op, logic [7:0] idx, logic [7:0] val,
                               logic [11:0] gx, logic [11:0] gz,
                               bit typed, logic signed [40:0] height);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_table_index <= idx;
      req_table_value <= val;
      req_grid_x <= gx;
      req_grid_z <= gz;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD) perm[idx] = val;
      else heights_due = {heights_due, (typed ? height : terrain_height(gx, gz))};
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BASE_FREQUENCY: frequency = data[23:0];
         CSR_BASE_AMPLITUDE: amplitude = data;
         CSR_OCTAVE_COUNT:   octaves = data[4:0];
         default: ;
      endcase
   endtask

   // Registers change only once the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (heights_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (heights_due.size() == 0) begin
            report_mismatch("unexpected height", rsp_height, 0);
         end else begin
            if (rsp_height !== heights_due[0])
               report_mismatch("height", rsp_height, heights_due[0]);
            void'(heights_due.pop_front());
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("perlin_fbm_height_sampler: mismatch");
         $finish;
      end
   end

   initial begin
      logic [7:0] shuffled[256];
      logic [7:0] swap;
      logic [23:0] freq_set[6];
      logic [31:0] amp_set[6];
      logic [4:0]  oct_set[6];
      int j;
      frequency = 24'd1311;
      amplitude = 32'd65536;
      octaves = 5'd4;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every table entry is written before any sample can read it.
      for (int i = 0; i < 256; i++) shuffled[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         swap = shuffled[i];
         shuffled[i] = shuffled[j];
         shuffled[j] = swap;
      end
      send_idle = 34;
      recv_idle = 57;
      for (int i = 0; i < 256; i++)
         send_request(OP_LOAD, 8'(i), shuffled[i], '0, '0, 1'b0, '0);

      foreach (directed[i])
         send_request(directed[i].op, directed[i].idx, directed[i].val, directed[i].gx,
                      directed[i].gz, directed[i].typed, directed[i].height);

      freq_set = '{24'd1311, 24'hFFFFFF, 24'd0, 24'($urandom), 24'd65536, 24'($urandom_range(65535))};
      amp_set = '{32'd65536, 32'hFFFFFFFF, 32'd12345, $urandom, $urandom, $urandom};
      oct_set = '{5'd4, 5'd16, 5'd31, 5'd0, 5'd5, 5'($urandom_range(1, 8))};
      for (int p = 0; p < 6; p++) begin
         settle();
         if (p < 2) begin
            send_idle = 34;
            recv_idle = 57;
         end else if (p < 4) begin
            send_idle = 57;
            recv_idle = 34;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_register(CSR_BASE_FREQUENCY, 32'(freq_set[p]));
         write_register(CSR_BASE_AMPLITUDE, amp_set[p]);
         write_register(CSR_OCTAVE_COUNT, 32'(oct_set[p]));
         // A write to an unused index must leave every register alone.
         if (p == 3) write_register(CSR_UNUSED, $urandom);
         for (int i = 0; i < 63; i++) begin
            if ($urandom_range(99) < 20)
               send_request(OP_LOAD, 8'($urandom), 8'($urandom), '0, '0, 1'b0, '0);
            else
               send_request(OP_SAMPLE, 8'($urandom), 8'($urandom), 12'($urandom),
                            12'($urandom), 1'b0, '0);
         end
      end

      settle();
      if (errors == 0) begin
         $display("perlin_fbm_height_sampler: match");
      end else begin
         $display("perlin_fbm_height_sampler: mismatch");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/pfh_pkg.sv
hdl/pfh_front.sv
hdl/pfh_back.sv
hdl/perlin_fbm_height_sampler.sv
sim/perlin_fbm_height_sampler_tb.sv
